// ===== hdl/ssr_pkg.sv =====
// Shared constants, register codes and types of the sensor smoothing reporter.
`timescale 1ns / 1ps

package ssr_pkg;

   // Raw converter sample width and configuration register width.
   localparam int SAMPLE_BITS = 10;
   localparam int CFG_BITS    = 8;

   // Result widths: temperature in signed degrees, battery in tenths of a volt.
   localparam int TEMP_BITS   = 10;
   localparam int BATT_BITS   = 10;
   localparam int AVG_B_BITS  = 11;

   // Temperature conversion: (raw*330 - 50*2^SAMPLE_BITS) / 2^SAMPLE_BITS.
   localparam int TEMP_GAIN     = 330;
   localparam int TEMP_OFFSET   = 50;
   localparam int TEMP_PROD_BITS = SAMPLE_BITS + 9;
   localparam int TEMP_DIFF_BITS = TEMP_PROD_BITS + 1;

   // Battery conversion: quotient of a sample by 255.
   localparam int BATT_SUM_BITS = SAMPLE_BITS + 1;
   localparam int BATT_Q_BITS   = BATT_SUM_BITS - 8;

   // Smoothing numerator and shared divider widths.
   localparam int NUM_BITS     = 20;
   localparam int DIV_CNT_BITS = $clog2(NUM_BITS);

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] REG_REPORT_CYCLE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SMOOTHING    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_BATT_SCALE   = 2'd2;

   // Configuration reset values.
   localparam logic [CFG_BITS-1:0] REPORT_CYCLE_RESET = 8'd1;
   localparam logic [CFG_BITS-1:0] SMOOTHING_RESET    = 8'd8;
   localparam logic [CFG_BITS-1:0] BATT_SCALE_RESET   = 8'd33;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/ssr_if.sv =====
// Valid/ready channel interfaces for sample beats and report beats.
`timescale 1ns / 1ps

interface ssr_req_if;
   logic                               valid;
   logic                               ready;
   logic [ssr_pkg::SAMPLE_BITS-1:0]    temp_sample;
   logic [ssr_pkg::SAMPLE_BITS-1:0]    batt_sample;

   modport source (output valid, output temp_sample, output batt_sample, input ready);
   modport sink   (input valid, input temp_sample, input batt_sample, output ready);
endinterface

interface ssr_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ssr_pkg::TEMP_BITS-1:0] temp_celsius;
   logic [ssr_pkg::BATT_BITS-1:0]      battery_tenths;

   modport source (output valid, output temp_celsius, output battery_tenths, input ready);
   modport sink   (input valid, input temp_celsius, input battery_tenths, output ready);
endinterface

// ===== hdl/ssr_conv.sv =====
// Conversion of raw samples to degrees Celsius and tenths of a volt.
`timescale 1ns / 1ps

module ssr_conv (
   input  logic [ssr_pkg::SAMPLE_BITS-1:0]    temp_sample,
   input  logic [ssr_pkg::SAMPLE_BITS-1:0]    batt_sample,
   input  logic [ssr_pkg::CFG_BITS-1:0]       batt_scale,
   output logic signed [ssr_pkg::TEMP_BITS-1:0] temp_value,
   output logic [ssr_pkg::BATT_BITS-1:0]      batt_value
);

   localparam int TPB = ssr_pkg::TEMP_PROD_BITS;
   localparam int TDB = ssr_pkg::TEMP_DIFF_BITS;
   localparam int SB  = ssr_pkg::SAMPLE_BITS;
   localparam logic signed [TDB-1:0] OFFSET_SCALED =
      TDB'(ssr_pkg::TEMP_OFFSET * (1 << SB));

   logic [TPB-1:0]                 temp_prod;
   logic signed [TDB-1:0]          temp_diff;
   logic signed [TDB-1:0]          temp_shift;
   logic signed [TDB-1:0]          temp_trunc;
   logic [ssr_pkg::BATT_SUM_BITS-1:0] batt_sum;
   logic [ssr_pkg::BATT_Q_BITS-1:0]   batt_quot;
   logic [ssr_pkg::BATT_Q_BITS+ssr_pkg::CFG_BITS-1:0] batt_prod;

   // Temperature: scale, remove the offset, divide by the full scale toward zero.
   always_comb begin
      temp_prod  = TPB'(temp_sample) * TPB'(ssr_pkg::TEMP_GAIN);
      temp_diff  = $signed({1'b0, temp_prod}) - OFFSET_SCALED;
      temp_shift = temp_diff >>> SB;
      if (temp_diff[TDB-1] && (temp_diff[SB-1:0] != '0)) begin
         temp_trunc = temp_shift + TDB'(1);
      end else begin
         temp_trunc = temp_shift;
      end
      temp_value = temp_trunc[ssr_pkg::TEMP_BITS-1:0];
   end

   // Battery: floor(raw / 255) by the reciprocal identity (x + x/256 + 1) / 256, times the scale.
   always_comb begin
      batt_sum   = ssr_pkg::BATT_SUM_BITS'(batt_sample)
                 + ssr_pkg::BATT_SUM_BITS'(batt_sample >> 8)
                 + ssr_pkg::BATT_SUM_BITS'(1);
      batt_quot  = batt_sum[ssr_pkg::BATT_SUM_BITS-1:8];
      batt_prod  = (ssr_pkg::BATT_Q_BITS+ssr_pkg::CFG_BITS)'(batt_quot)
                 * (ssr_pkg::BATT_Q_BITS+ssr_pkg::CFG_BITS)'(batt_scale);
      batt_value = batt_prod[ssr_pkg::BATT_BITS-1:0];
   end

endmodule

// ===== hdl/ssr_div.sv =====
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module ssr_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ssr_pkg::NUM_BITS-1:0]    dividend,
   input  logic [ssr_pkg::CFG_BITS-1:0]    divisor,
   output ssr_pkg::div_status_type         status,
   output logic [ssr_pkg::NUM_BITS-1:0]    quotient
);

   localparam int NB = ssr_pkg::NUM_BITS;
   localparam int CB = ssr_pkg::CFG_BITS;
   localparam int KB = ssr_pkg::DIV_CNT_BITS;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [KB-1:0] cnt_ff, cnt_in;
   logic [NB-1:0] work_ff, work_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic [CB-1:0] dsr_ff, dsr_in;
   logic [CB:0]   rem_shift;
   logic [CB:0]   rem_diff;
   logic          fits;

   // One shift-and-subtract step; the dividend shifts out as quotient bits shift in.
   always_comb begin
      rem_shift = {rem_ff, work_ff[NB-1]};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      fits      = (rem_shift >= {1'b0, dsr_ff});
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[NB-2:0], fits};
         rem_in  = fits ? rem_diff[CB-1:0] : rem_shift[CB-1:0];
         cnt_in  = cnt_ff + KB'(1);
         if (cnt_ff == KB'(NB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = work_ff;

endmodule

// ===== hdl/sensor_smoothing_reporter.sv =====
// Each tick but the first makes two 20-step passes of the shared divider, temperature then
// battery; the input takes no new sample beat until the tick is finished.
// The first tick after reset loads the averages directly, without the divider.
// A pending report waits in the output register; beats are taken till another report is due.
// Reset is synchronous and active high; it restores configuration and control registers, clears the averages.
`timescale 1ns / 1ps

module sensor_smoothing_reporter (
   input  logic                                clock,
   input  logic                                reset,
   ssr_req_if.sink                             req_if,
   ssr_rsp_if.source                           rsp_if,
   input  logic                                csr_wen,
   input  logic [ssr_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [ssr_pkg::CFG_BITS-1:0]        csr_wdata
);

   localparam int NB = ssr_pkg::NUM_BITS;
   localparam int CB = ssr_pkg::CFG_BITS;
   localparam int TB = ssr_pkg::TEMP_BITS;
   localparam int BB = ssr_pkg::BATT_BITS;
   localparam int AB = ssr_pkg::AVG_B_BITS;

   localparam int STATE_BITS = 3;
   localparam logic [STATE_BITS-1:0] S_IDLE   = 3'd0;
   localparam logic [STATE_BITS-1:0] S_LOAD_T = 3'd1;
   localparam logic [STATE_BITS-1:0] S_DIV_T  = 3'd2;
   localparam logic [STATE_BITS-1:0] S_LOAD_B = 3'd3;
   localparam logic [STATE_BITS-1:0] S_DIV_B  = 3'd4;
   localparam logic [STATE_BITS-1:0] S_FINISH = 3'd5;

   logic [STATE_BITS-1:0]  state_ff, state_in;
   logic [CB-1:0]          report_cycle_ff, report_cycle_in;
   logic [CB-1:0]          smoothing_ff, smoothing_in;
   logic [CB-1:0]          batt_scale_ff, batt_scale_in;
   logic signed [TB-1:0]   avg_t_ff, avg_t_in;
   logic [AB-1:0]          avg_b_ff, avg_b_in;
   logic [CB-1:0]          tick_ff, tick_in;
   logic                   first_ff, first_in;
   logic signed [TB-1:0]   next_t_ff, next_t_in;
   logic [BB-1:0]          next_b_ff, next_b_in;
   logic                   neg_ff, neg_in;
   logic                   valid_ff, valid_in;
   logic signed [TB-1:0]   out_t_ff, out_t_in;
   logic [BB-1:0]          out_b_ff, out_b_in;

   logic signed [TB-1:0]   conv_t;
   logic [BB-1:0]          conv_b;
   logic                   accept;
   logic [CB-1:0]          s_eff;
   logic [CB-1:0]          s_minus;
   logic signed [NB-1:0]   prev_sel;
   logic signed [NB-1:0]   next_sel;
   logic signed [NB-1:0]   numer;
   logic [NB-1:0]          numer_mag;
   logic                   div_start;
   ssr_pkg::div_status_type div_st;
   logic [NB-1:0]          quot;
   logic [NB-1:0]          quot_signed;
   logic [CB:0]            next_count;
   logic                   report;
   logic                   out_free;

   // Raw sample conversion.
   ssr_conv u_conv (
      .temp_sample (req_if.temp_sample),
      .batt_sample (req_if.batt_sample),
      .batt_scale  (batt_scale_ff),
      .temp_value  (conv_t),
      .batt_value  (conv_b)
   );

   // Shared divider for both smoothing quotients.
   ssr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer_mag),
      .divisor  (s_eff),
      .status   (div_st),
      .quotient (quot)
   );

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE);
   assign rsp_if.valid  = valid_ff;
   assign rsp_if.temp_celsius   = out_t_ff;
   assign rsp_if.battery_tenths = out_b_ff;
   assign out_free      = !valid_ff || rsp_if.ready;

   // Smoothing numerator ((s-1)*prev + next + s/2) for the channel in turn.
   always_comb begin
      s_eff   = (smoothing_ff == '0) ? CB'(1) : smoothing_ff;
      s_minus = s_eff - CB'(1);
      if (state_ff == S_LOAD_B) begin
         prev_sel = $signed({{(NB-AB){1'b0}}, avg_b_ff});
         next_sel = $signed({{(NB-BB){1'b0}}, next_b_ff});
      end else begin
         prev_sel = $signed({{(NB-TB){avg_t_ff[TB-1]}}, avg_t_ff});
         next_sel = $signed({{(NB-TB){next_t_ff[TB-1]}}, next_t_ff});
      end
      numer     = $signed({{(NB-CB){1'b0}}, s_minus}) * prev_sel + next_sel
                + $signed({{(NB-CB){1'b0}}, s_eff >> 1});
      numer_mag = numer[NB-1] ? NB'(-numer) : NB'(numer);
      quot_signed = neg_ff ? NB'(-quot) : quot;
   end

   // Report test on the incremented tick count.
   always_comb begin
      next_count = {1'b0, tick_ff} + (CB+1)'(1);
      report     = (next_count >= {1'b0, report_cycle_ff});
   end

   // Configuration writes; unknown indexes are ignored.
   always_comb begin
      report_cycle_in = report_cycle_ff;
      smoothing_in    = smoothing_ff;
      batt_scale_in   = batt_scale_ff;
      if (csr_wen) begin
         unique case (csr_index)
            ssr_pkg::REG_REPORT_CYCLE: report_cycle_in = csr_wdata;
            ssr_pkg::REG_SMOOTHING:    smoothing_in    = csr_wdata;
            ssr_pkg::REG_BATT_SCALE:   batt_scale_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: convert, smooth temperature, smooth battery (or load both on the first tick), count and report.
   always_comb begin
      state_in  = state_ff;
      avg_t_in  = avg_t_ff;
      avg_b_in  = avg_b_ff;
      tick_in   = tick_ff;
      first_in  = first_ff;
      next_t_in = next_t_ff;
      next_b_in = next_b_ff;
      neg_in    = neg_ff;
      div_start = 1'b0;
      valid_in  = valid_ff && !rsp_if.ready;
      out_t_in  = out_t_ff;
      out_b_in  = out_b_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               next_t_in = conv_t;
               next_b_in = conv_b;
               state_in  = S_LOAD_T;
            end
         end
         S_LOAD_T: begin
            first_in = 1'b0;
            if (first_ff) begin
               avg_t_in = next_t_ff;
               avg_b_in = AB'(next_b_ff);
               state_in = S_FINISH;
            end else begin
               div_start = 1'b1;
               neg_in    = numer[NB-1];
               state_in  = S_DIV_T;
            end
         end
         S_DIV_T: begin
            if (div_st.done) begin
               avg_t_in = quot_signed[TB-1:0];
               state_in = S_LOAD_B;
            end
         end
         S_LOAD_B: begin
            div_start = 1'b1;
            neg_in    = numer[NB-1];
            state_in  = S_DIV_B;
         end
         S_DIV_B: begin
            if (div_st.done) begin
               avg_b_in = quot_signed[AB-1:0];
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!report) begin
               tick_in  = next_count[CB-1:0];
               state_in = S_IDLE;
            end else if (out_free) begin
               tick_in  = '0;
               valid_in = 1'b1;
               out_t_in = avg_t_ff;
               out_b_in = avg_b_ff[BB-1:0];
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         report_cycle_ff <= ssr_pkg::REPORT_CYCLE_RESET;
         smoothing_ff    <= ssr_pkg::SMOOTHING_RESET;
         batt_scale_ff   <= ssr_pkg::BATT_SCALE_RESET;
         avg_t_ff        <= '0;
         avg_b_ff        <= '0;
         tick_ff         <= '0;
         first_ff        <= 1'b1;
         valid_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         report_cycle_ff <= report_cycle_in;
         smoothing_ff    <= smoothing_in;
         batt_scale_ff   <= batt_scale_in;
         avg_t_ff        <= avg_t_in;
         avg_b_ff        <= avg_b_in;
         tick_ff         <= tick_in;
         first_ff        <= first_in;
         valid_ff        <= valid_in;
      end
      next_t_ff <= next_t_in;
      next_b_ff <= next_b_in;
      neg_ff    <= neg_in;
      out_t_ff  <= out_t_in;
      out_b_ff  <= out_b_in;
   end

   // The divider only runs while the sequencer waits on it.
   a_div_busy_state: assert property (@(posedge clock) disable iff (reset)
      div_st.busy |-> (state_ff == S_DIV_T || state_ff == S_DIV_B))
      else $error("divider busy outside a divide state");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> (state_ff == S_DIV_T || state_ff == S_DIV_B))
      else $error("divider result arrived outside a divide state");

   // A sample beat closes the input until its tick is finished.
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_if.ready)
      else $error("input stayed open after a sample beat");

   // The first-tick flag clears only when the first tick loads the averages.
   a_first_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(first_ff) |-> ($past(state_ff) == S_LOAD_T))
      else $error("first-tick flag cleared outside the load step");

   // A report restarts the tick count.
   a_report_clears_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && report && out_free) |=> (tick_ff == '0 && valid_ff))
      else $error("report did not restart the tick count");

endmodule

// ===== bench/ssr_report_checker.sv =====
// Checker that mirrors the register file, predicts report beats and compares them.
`timescale 1ns / 1ps

module ssr_report_checker (
   input  logic                             clock,
   input  logic                             reset,
   ssr_req_if                               req_mon,
   ssr_rsp_if                               rsp_mon,
   input  logic                             csr_wen,
   input  logic [ssr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ssr_pkg::CFG_BITS-1:0]     csr_wdata,
   output int                               fail_count,
   output int                               pending
);

   localparam int BATT_STEP = 255;
   localparam int MAX_SHOWN = 10;
   localparam int SB        = ssr_pkg::SAMPLE_BITS;
   localparam int CB        = ssr_pkg::CFG_BITS;
   localparam int TW        = ssr_pkg::TEMP_BITS;
   localparam int BW        = ssr_pkg::BATT_BITS;
   localparam int AB        = ssr_pkg::AVG_B_BITS;

   typedef struct packed {
      logic signed [TW-1:0] temp_celsius;
      logic [BW-1:0]        battery_tenths;
   } report_type;

   // Reports predicted from accepted sample beats, oldest first.
   report_type            report_queue[$];

   logic [CB-1:0]         cycle_reg;
   logic [CB-1:0]         smooth_reg;
   logic [CB-1:0]         scale_reg;
   int                    avg_temp;
   logic [AB-1:0]         avg_batt;
   logic [CB-1:0]         tick_count;
   logic                  first_tick;
   int                    mismatches;

   assign pending    = report_queue.size();
   assign fail_count = mismatches;

   // Folds one tick into both running averages and queues a report when the count is due.
   function automatic void fold_tick(input logic [SB-1:0] t_raw,
                                     input logic [SB-1:0] b_raw);
      int         full_scale;
      int         temp_now;
      int         batt_now;
      int         s;
      int         next_count;
      report_type rpt;
      full_scale = 1 << SB;
      // Signed division truncates toward zero, as the conversion requires.
      temp_now = (int'(t_raw) * ssr_pkg::TEMP_GAIN - ssr_pkg::TEMP_OFFSET * full_scale)
               / full_scale;
      batt_now = (int'(b_raw) / BATT_STEP) * int'(scale_reg);
      // A zero smoothing factor behaves as one.
      s = (smooth_reg == '0) ? 1 : int'(smooth_reg);
      if (first_tick) begin
         avg_temp = temp_now;
         avg_batt = AB'(batt_now);
      end else begin
         avg_temp = ((s - 1) * avg_temp + temp_now + s / 2) / s;
         avg_batt = AB'(((s - 1) * int'(avg_batt) + batt_now + s / 2) / s);
      end
      first_tick = 1'b0;
      // The count test uses count+1 >= cycle, so a lowered cycle reports at once.
      next_count = int'(tick_count) + 1;
      if (next_count >= int'(cycle_reg)) begin
         tick_count         = '0;
         rpt.temp_celsius   = avg_temp[TW-1:0];
         rpt.battery_tenths = avg_batt[BW-1:0];
         report_queue.push_back(rpt);
      end else begin
         tick_count = CB'(next_count);
      end
   endfunction

   always @(posedge clock) begin
      report_type want;
      if (reset) begin
         cycle_reg  = ssr_pkg::REPORT_CYCLE_RESET;
         smooth_reg = ssr_pkg::SMOOTHING_RESET;
         scale_reg  = ssr_pkg::BATT_SCALE_RESET;
         avg_temp   = 0;
         avg_batt   = '0;
         tick_count = '0;
         first_tick = 1'b1;
         mismatches = 0;
         report_queue.delete();
      end else begin
         // Report beats are checked against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (report_queue.size() == 0) begin
               if (mismatches < MAX_SHOWN)
                  $display("%0t: report beat with none expected: temp %0d batt %0d",
                           $time, rsp_mon.temp_celsius, rsp_mon.battery_tenths);
               mismatches++;
            end else begin
               want = report_queue.pop_front();
               if (rsp_mon.temp_celsius !== want.temp_celsius ||
                   rsp_mon.battery_tenths !== want.battery_tenths) begin
                  if (mismatches < MAX_SHOWN)
                     $display({"%0t: report mismatch: expected temp %0d batt %0d,",
                               " got temp %0d batt %0d"},
                              $time, want.temp_celsius, want.battery_tenths,
                              rsp_mon.temp_celsius, rsp_mon.battery_tenths);
                  mismatches++;
               end
            end
         end

         // Register writes; an unused index changes nothing.
         if (csr_wen) begin
            unique case (csr_index)
               ssr_pkg::REG_REPORT_CYCLE: cycle_reg  = csr_wdata;
               ssr_pkg::REG_SMOOTHING:    smooth_reg = csr_wdata;
               ssr_pkg::REG_BATT_SCALE:   scale_reg  = csr_wdata;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready)
            fold_tick(req_mon.temp_sample, req_mon.batt_sample);
      end
   end

endmodule

// ===== bench/sensor_smoothing_reporter_tb.sv =====
// Top of the sensor smoothing reporter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sensor_smoothing_reporter_tb;

   localparam int SB = ssr_pkg::SAMPLE_BITS;
   localparam int CB = ssr_pkg::CFG_BITS;
   localparam int IB = ssr_pkg::CSR_IDX_BITS;
   localparam logic [IB-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 60;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 3000;

   typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_wen;
   logic [IB-1:0]           csr_index;
   logic [CB-1:0]           csr_wdata;
   int                      fail_count;
   int                      pending;
   pace_type                pace = PACE_FREE;
   int                      hold_asked = 0;
   int                      hold_served = 0;
   int                      hold_left = 0;
   int                      quiet_cycles = 0;

   ssr_req_if req_bus ();
   ssr_rsp_if rsp_bus ();

   sensor_smoothing_reporter dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ssr_report_checker report_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Percentage of cycles in which one side holds back under the current pacing.
   function automatic int idle_pct(input bit recv_side);
      unique case (pace)
         PACE_SEND_IDLE:  return recv_side ? 0 : 61;
         PACE_RECV_STALL: return recv_side ? 61 : 0;
         PACE_BOTH:       return 20;
         default:         return 0;
      endcase
   endfunction

   // Report receiver: random stalls, plus a long hold-off whenever one is requested.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_asked) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
         end
      end
   end

   // Watchdog on cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one sample beat, with random gaps before it, and returns after acceptance.
   task automatic send_tick(input logic [SB-1:0] t_raw,
                            input logic [SB-1:0] b_raw);
      while ($urandom_range(0, 99) < idle_pct(1'b0)) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.temp_sample <= t_raw;
      req_bus.batt_sample <= b_raw;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   // Stops offering until every predicted report has arrived, then waits a while longer.
   task automatic drain(input int extra);
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IB-1:0] idx,
                            input logic [CB-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   // Settles the block so that no tick is in flight, then sets all three registers.
   task automatic program_regs(input logic [CB-1:0] cycle,
                               input logic [CB-1:0] smooth,
                               input logic [CB-1:0] scale);
      drain(SETTLE_CYCLES);
      write_reg(ssr_pkg::REG_REPORT_CYCLE, cycle);
      write_reg(ssr_pkg::REG_SMOOTHING, smooth);
      write_reg(ssr_pkg::REG_BATT_SCALE, scale);
   endtask

   // Raw samples weighted toward the ends of the range and the conversion edges.
   function automatic logic [SB-1:0] pick_sample(input bit batt);
      unique case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: begin
            if (batt)
               return SB'(255 * $urandom_range(1, 4) - $urandom_range(0, 1));
            return SB'($urandom_range(150, 160));
         end
         default: return SB'($urandom);
      endcase
   endfunction

   // Random ticks; halfway, the sender waits for all reports; squeeze asks for a hold-off.
   task automatic run_phase(input int count, input bit squeeze);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            drain(0);
         if (squeeze && i == 20)
            hold_asked++;
         send_tick(pick_sample(1'b0), pick_sample(1'b1));
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wen             = 1'b0;
      csr_index           = ssr_pkg::REG_REPORT_CYCLE;
      csr_wdata           = '0;
      req_bus.valid       = 1'b0;
      req_bus.temp_sample = '0;
      req_bus.batt_sample = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Defaults after reset; the first tick loads both averages directly.
      send_tick(10'd512, 10'd300);
      send_tick(10'd0, 10'd0);
      send_tick(10'd1023, 10'd1023);
      send_tick(10'd1, 10'd254);
      send_tick(10'd155, 10'd255);
      send_tick(10'd156, 10'd510);
      send_tick(10'd1023, 10'd765);
      send_tick(10'd0, 10'd1020);

      // Zero smoothing factor, widest scale, report on every tick; a spare index is ignored.
      program_regs(8'd0, 8'd0, 8'd255);
      write_reg(REG_SPARE, 8'hAA);
      send_tick(10'd0, 10'd1023);
      send_tick(10'd1023, 10'd0);
      send_tick(10'd700, 10'd1023);
      send_tick(10'd3, 10'd511);
      send_tick(10'd1023, 10'd1023);

      // Lowered report cycle: the count reaches five, then the cycle drops below it.
      program_regs(8'd10, 8'd1, 8'd0);
      repeat (5) send_tick(pick_sample(1'b0), pick_sample(1'b1));
      drain(SETTLE_CYCLES);
      write_reg(ssr_pkg::REG_REPORT_CYCLE, 8'd3);
      repeat (4) send_tick(pick_sample(1'b0), pick_sample(1'b1));

      // Every tick reports while the receiver holds off long enough to back up the input.
      pace = PACE_FREE;
      program_regs(8'd1, 8'd255, 8'd255);
      run_phase(150, 1'b1);

      // Longest report cycle: reports are rare here.
      pace = PACE_SEND_IDLE;
      program_regs(8'd255, 8'd2, 8'd33);
      run_phase(260, 1'b0);

      for (int p = 0; p < 6; p++) begin
         pace = pace_type'((p + 2) % 4);
         program_regs(CB'($urandom_range(0, 12)), CB'($urandom_range(0, 255)),
                      CB'($urandom));
         run_phase(170, 1'b0);
      end

      drain(SETTLE_CYCLES);
      if (fail_count == 0 && pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sensor_smoothing_reporter.f =====
hdl/ssr_pkg.sv
hdl/ssr_if.sv
hdl/ssr_conv.sv
hdl/ssr_div.sv
hdl/sensor_smoothing_reporter.sv
bench/ssr_report_checker.sv
bench/sensor_smoothing_reporter_tb.sv
